// File: hdl/icv_pkg.sv
// Shared types and constants for the streaming 2-D convolution block.
// Used by every module of the block but icv_ram; depends on nothing.
package icv_pkg;

  // Geometry limits and number formats.
  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MAX_KERNEL  = 7;
  localparam int PIXEL_BITS  = 16;
  localparam int COEF_BITS   = 18;
  localparam int COEF_FRAC   = 12;
  localparam int RING_ROWS   = MAX_KERNEL + 1;
  localparam int QUEUE_DEPTH = 4;

  // Field and counter widths.
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS  = 12;
  localparam int HEIGHT_BITS = 13;
  localparam int ROW_BITS    = 13;
  localparam int EROW_BITS   = 12;
  localparam int KDIM_BITS   = 3;
  localparam int HALF_BITS   = 2;
  localparam int SLOT_BITS   = $clog2(RING_ROWS);
  localparam int CIDX_BITS   = 6;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int PROD_BITS   = PIXEL_BITS + COEF_BITS;
  localparam int ROWSUM_BITS = PROD_BITS + 3;
  localparam int ACC_BITS    = PROD_BITS + 6;
  localparam int QUOT_BITS   = ACC_BITS - COEF_FRAC;
  localparam int PIX_MAX     = 2 ** (PIXEL_BITS - 1) - 1;
  localparam int PIX_MIN     = -(2 ** (PIXEL_BITS - 1));

  // Item opcodes.
  localparam logic [1:0] OP_COEF  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_KCOLS  = 2'd2;
  localparam logic [1:0] CFG_KROWS  = 2'd3;

  // Command passed from the front end to the back end through the queue.
  typedef struct packed {
    logic                        is_coef;
    logic [CIDX_BITS-1:0]        coef_idx;
    logic signed [COEF_BITS-1:0] coef_val;
    logic                        wr;
    logic [SLOT_BITS-1:0]        wr_slot;
    logic [COL_BITS-1:0]         col;
    logic signed [PIXEL_BITS-1:0] pix;
    logic                        ld;
    logic [SLOT_BITS-1:0]        rd_base;
    logic                        emit;
    logic                        err;
    logic [MAX_KERNEL-1:0]       rowm;
    logic [MAX_KERNEL-1:0]       colm;
    logic [COL_BITS-1:0]         ec;
    logic [EROW_BITS-1:0]        er;
    logic                        fend;
  } cmd_t;

  // Result bookkeeping that rides along the adder pipeline.
  typedef struct packed {
    logic                 err;
    logic [COL_BITS-1:0]  ec;
    logic [EROW_BITS-1:0] er;
    logic                 fend;
  } meta_t;

endpackage

// File: hdl/icv_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// A read of the address being written returns the new data. No dependencies.
module icv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port with write-first forwarding.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
    end
  end

endmodule

// File: hdl/icv_front.sv
// Front end: configuration registers, position counters and item classification.
// Turns each accepted beat into a command for the back end. Uses icv_pkg.
module icv_front import icv_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr,
  input  logic [1:0]                   cfg_index,
  input  logic [HEIGHT_BITS-1:0]       cfg_data,
  input  logic                         item_acc,
  input  logic [1:0]                   opcode,
  input  logic [CIDX_BITS-1:0]         coef_index,
  input  logic signed [COEF_BITS-1:0]  coef_value,
  input  logic signed [PIXEL_BITS-1:0] pixel_value,
  output logic                         push,
  output cmd_t                         cmd,
  output logic [KDIM_BITS-1:0]         win_top
);

  logic [WIDTH_BITS-1:0]  img_w;
  logic [HEIGHT_BITS-1:0] img_h;
  logic [KDIM_BITS-1:0]   k_cols;
  logic [KDIM_BITS-1:0]   k_rows;
  logic [COL_BITS-1:0]    in_col;
  logic [ROW_BITS-1:0]    in_row;
  logic [COL_BITS-1:0]    emit_col;
  logic [EROW_BITS-1:0]   emit_row;

  logic [WIDTH_BITS-1:0]  w_eff;
  logic [WIDTH_BITS-1:0]  wm1;
  logic [HEIGHT_BITS-1:0] h_eff;
  logic [HALF_BITS-1:0]   hr;
  logic [HALF_BITS-1:0]   hc;
  logic [HALF_BITS-1:0]   lag;
  logic                   kbad;
  logic                   is_pix;
  logic                   do_emit;
  logic                   do_ld;
  logic [WIDTH_BITS-1:0]  ec_inc;
  logic [HEIGHT_BITS-1:0] er_inc;
  logic [WIDTH_BITS-1:0]  ic_inc;
  logic                   col_wrap;
  logic                   in_wrap;
  logic                   fend;
  logic [ROW_BITS-1:0]    rsum [MAX_KERNEL];
  logic [WIDTH_BITS-1:0]  csum [MAX_KERNEL];
  logic [MAX_KERNEL-1:0]  rowm;
  logic [MAX_KERNEL-1:0]  colm;

  // Effective geometry: sizes clamped to the supported range.
  always_comb begin
    if (img_w == '0) begin
      w_eff = WIDTH_BITS'(1);
    end else if (img_w > WIDTH_BITS'(MAX_WIDTH)) begin
      w_eff = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      w_eff = img_w;
    end
    if (img_h == '0) begin
      h_eff = HEIGHT_BITS'(1);
    end else if (img_h > HEIGHT_BITS'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = img_h;
    end
  end

  // Kernel half sizes and the horizontal lag, which is capped by the row width.
  assign hr   = k_rows[2:1];
  assign hc   = k_cols[2:1];
  assign wm1  = w_eff - 1'b1;
  assign lag  = (WIDTH_BITS'(hc) < wm1) ? hc : wm1[HALF_BITS-1:0];
  assign kbad = !k_cols[0] || !k_rows[0];
  assign win_top = {1'b0, hc} + {1'b0, lag};

  // Position bookkeeping for the current beat.
  assign is_pix   = (opcode == OP_PIXEL) || (opcode == OP_DRAIN);
  assign do_ld    = in_row >= ROW_BITS'(hr);
  assign do_emit  = (in_row > ROW_BITS'(hr)) ||
                    (in_row == ROW_BITS'(hr) && in_col >= COL_BITS'(lag));
  assign ec_inc   = {1'b0, emit_col} + 1'b1;
  assign er_inc   = {1'b0, emit_row} + 1'b1;
  assign ic_inc   = {1'b0, in_col} + 1'b1;
  assign col_wrap = ec_inc >= w_eff;
  assign in_wrap  = ic_inc >= w_eff;
  assign fend     = col_wrap && (er_inc >= h_eff);

  // Window taps that fall inside both the kernel and the image.
  always_comb begin
    for (int k = 0; k < MAX_KERNEL; k++) begin
      rsum[k] = {1'b0, emit_row} + ROW_BITS'(k);
      csum[k] = {1'b0, emit_col} + WIDTH_BITS'(k);
      rowm[k] = (KDIM_BITS'(k) < k_rows) && (rsum[k] >= ROW_BITS'(hr)) &&
                ({1'b0, rsum[k]} < ({1'b0, h_eff} + (ROW_BITS + 1)'(hr)));
      colm[k] = (KDIM_BITS'(k) < k_cols) && (csum[k] >= WIDTH_BITS'(hc)) &&
                ({1'b0, csum[k]} < ({1'b0, w_eff} + (WIDTH_BITS + 1)'(hc)));
    end
  end

  // Command for the back end.
  always_comb begin
    cmd          = '0;
    cmd.is_coef  = (opcode == OP_COEF);
    cmd.coef_idx = coef_index;
    cmd.coef_val = coef_value;
    if (is_pix) begin
      if (kbad) begin
        cmd.emit = 1'b1;
        cmd.err  = 1'b1;
      end else begin
        cmd.wr      = in_row < ROW_BITS'(h_eff);
        cmd.wr_slot = in_row[SLOT_BITS-1:0];
        cmd.col     = in_col;
        cmd.pix     = (opcode == OP_PIXEL) ? pixel_value : '0;
        cmd.ld      = do_ld;
        cmd.rd_base = in_row[SLOT_BITS-1:0] - SLOT_BITS'({hr, 1'b0});
        cmd.emit    = do_emit;
        cmd.rowm    = rowm;
        cmd.colm    = colm;
        cmd.ec      = emit_col;
        cmd.er      = emit_row;
        cmd.fend    = do_emit && fend;
      end
    end
  end

  assign push = item_acc && (opcode != OP_NONE);

  // Configuration registers and frame counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w    <= WIDTH_BITS'(640);
      img_h    <= HEIGHT_BITS'(480);
      k_cols   <= KDIM_BITS'(3);
      k_rows   <= KDIM_BITS'(3);
      in_col   <= '0;
      in_row   <= '0;
      emit_col <= '0;
      emit_row <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_WIDTH:  img_w  <= cfg_data[WIDTH_BITS-1:0];
        CFG_HEIGHT: img_h  <= cfg_data;
        CFG_KCOLS:  k_cols <= cfg_data[KDIM_BITS-1:0];
        CFG_KROWS:  k_rows <= cfg_data[KDIM_BITS-1:0];
      endcase
      in_col   <= '0;
      in_row   <= '0;
      emit_col <= '0;
      emit_row <= '0;
    end else if (item_acc && is_pix && !kbad) begin
      if (do_emit && fend) begin
        // Last result of the frame: start over.
        in_col   <= '0;
        in_row   <= '0;
        emit_col <= '0;
        emit_row <= '0;
      end else begin
        if (do_emit) begin
          if (col_wrap) begin
            emit_col <= '0;
            emit_row <= er_inc[EROW_BITS-1:0];
          end else begin
            emit_col <= ec_inc[COL_BITS-1:0];
          end
        end
        if (in_wrap) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= ic_inc[COL_BITS-1:0];
        end
      end
    end
  end

endmodule

// File: hdl/icv_queue.sv
// Short command queue between the front end and the back end.
// Register-based FIFO of cmd_t entries. Uses icv_pkg.
module icv_queue import icv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full    = count == (QPTR_BITS + 1)'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign pop_cmd = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/icv_back.sv
// Back end: line buffer banks, sliding window, coefficient registers, MAC array,
// adder pipeline and output register. Uses icv_pkg and icv_ram.
module icv_back import icv_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  cmd_t                          q_cmd,
  output logic                          pop,
  input  logic [KDIM_BITS-1:0]          win_top,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic signed [PIXEL_BITS-1:0]  out_pixel,
  output logic [COL_BITS-1:0]           out_col,
  output logic [EROW_BITS-1:0]          out_row,
  output logic                          frame_end,
  output logic                          status
);

  logic                          adv;
  logic signed [PIXEL_BITS-1:0]  bank_q [RING_ROWS];
  logic signed [PIXEL_BITS-1:0]  column [MAX_KERNEL];
  logic signed [PIXEL_BITS-1:0]  win [MAX_KERNEL][MAX_KERNEL];
  logic signed [COEF_BITS-1:0]   coef [MAX_KERNEL][MAX_KERNEL];
  logic signed [PROD_BITS-1:0]   prod [MAX_KERNEL][MAX_KERNEL];
  logic signed [ROWSUM_BITS-1:0] rowsum_d [MAX_KERNEL];
  logic signed [ROWSUM_BITS-1:0] rowsum [MAX_KERNEL];
  logic signed [ACC_BITS-1:0]    total_d;
  logic signed [ACC_BITS-1:0]    total;
  logic signed [ACC_BITS-1:0]    adj;
  logic signed [QUOT_BITS-1:0]   quot;
  logic signed [PIXEL_BITS-1:0]  sat;

  logic  p1_valid, p2_valid, p3_emit, p4_emit, p5_emit;
  cmd_t  p1_cmd, p2_cmd;
  meta_t p3_meta, p4_meta, p5_meta;

  // The whole pipeline moves unless a finished result is waiting to be taken.
  assign adv = !(out_valid && out_stall);
  assign pop = adv && !q_empty;

  // One line buffer bank per ring row; write and column read share a beat.
  for (genvar b = 0; b < RING_ROWS; b++) begin : g_bank
    icv_ram #(
      .WIDTH(PIXEL_BITS),
      .DEPTH(MAX_WIDTH)
    ) u_bank (
      .clk  (clk),
      .we   (pop && q_cmd.wr && q_cmd.wr_slot == SLOT_BITS'(b)),
      .waddr(q_cmd.col),
      .wdata(q_cmd.pix),
      .re   (adv),
      .raddr(q_cmd.col),
      .rdata(bank_q[b])
    );
  end

  // Stage valid bits and emit flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_emit   <= 1'b0;
      p4_emit   <= 1'b0;
      p5_emit   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      p1_valid  <= pop;
      p2_valid  <= p1_valid;
      p3_emit   <= p2_valid && p2_cmd.emit;
      p4_emit   <= p3_emit;
      p5_emit   <= p4_emit;
      out_valid <= p5_emit;
    end
  end

  // Command and bookkeeping payload along the stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_cmd       <= q_cmd;
      p2_cmd       <= p1_cmd;
      p3_meta.err  <= p2_cmd.err;
      p3_meta.ec   <= p2_cmd.ec;
      p3_meta.er   <= p2_cmd.er;
      p3_meta.fend <= p2_cmd.fend;
      p4_meta      <= p3_meta;
      p5_meta      <= p4_meta;
    end
  end

  // Rotate the bank outputs so that window row k holds kernel row k.
  always_comb begin
    for (int k = 0; k < MAX_KERNEL; k++) begin
      column[k] = bank_q[SLOT_BITS'(p1_cmd.rd_base + SLOT_BITS'(k))];
    end
  end

  // Window: the new column enters at the top tap and moves toward tap zero.
  for (genvar k = 0; k < MAX_KERNEL; k++) begin : g_wrow
    for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_wcol
      always_ff @(posedge clk) begin
        if (adv && p1_valid && p1_cmd.ld) begin
          if (KDIM_BITS'(j) == win_top) begin
            win[k][j] <= column[k];
          end else if (KDIM_BITS'(j) < win_top) begin
            if (j < MAX_KERNEL - 1) begin
              win[k][j] <= win[k][(j + 1) % MAX_KERNEL];
            end
          end
        end
      end

      // Coefficient register for kernel tap (k, j), loaded in item order.
      always_ff @(posedge clk) begin
        if (rst) begin
          coef[k][j] <= '0;
        end else if (adv && p2_valid && p2_cmd.is_coef &&
                     p2_cmd.coef_idx == CIDX_BITS'(k * MAX_KERNEL + j)) begin
          coef[k][j] <= p2_cmd.coef_val;
        end
      end

      // Product lane; taps outside the kernel or the image contribute zero.
      always_ff @(posedge clk) begin
        if (adv) begin
          if (p2_cmd.rowm[k] && p2_cmd.colm[j]) begin
            prod[k][j] <= win[k][j] * coef[k][j];
          end else begin
            prod[k][j] <= '0;
          end
        end
      end
    end
  end

  // Row sums, then the total.
  always_comb begin
    total_d = '0;
    for (int k = 0; k < MAX_KERNEL; k++) begin
      rowsum_d[k] = '0;
      for (int j = 0; j < MAX_KERNEL; j++) begin
        rowsum_d[k] = rowsum_d[k] + ROWSUM_BITS'(prod[k][j]);
      end
      total_d = total_d + ACC_BITS'(rowsum[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rowsum <= rowsum_d;
      total  <= total_d;
    end
  end

  // Truncate toward zero out of the fraction bits, then saturate.
  assign adj  = total + (total[ACC_BITS-1] ? ACC_BITS'((1 << COEF_FRAC) - 1) : ACC_BITS'(0));
  assign quot = $signed(adj[ACC_BITS-1:COEF_FRAC]);
  always_comb begin
    if (quot > QUOT_BITS'(PIX_MAX)) begin
      sat = PIXEL_BITS'(PIX_MAX);
    end else if (quot < QUOT_BITS'(PIX_MIN)) begin
      sat = PIXEL_BITS'(PIX_MIN);
    end else begin
      sat = quot[PIXEL_BITS-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel <= p5_meta.err ? '0 : sat;
      out_col   <= p5_meta.ec;
      out_row   <= p5_meta.er;
      frame_end <= p5_meta.fend;
      status    <= p5_meta.err;
    end
  end

endmodule

// File: hdl/image_convolution_2d_top.sv
// Streaming 2-D convolution, top level: front end, command queue and back end.
// Uses icv_pkg, icv_front, icv_queue and icv_back.
//
// The block takes one beat per clock while the queue has room and returns one
// result per clock in steady state while the output is not stalled. Pixels arrive
// in raster order and are filtered with an odd kernel of up to 7x7 with Q5.12
// coefficients; neighbors outside the image count as zero. Each result trails its
// pixel by kernel_rows/2 rows plus up to kernel_cols/2 columns of beats, and drain
// beats push out the tail of the frame. Inside the block a result passes from the
// command queue through the line buffer read, the window shift, the 49-lane
// multiplier array, a two-level adder tree and the output register.
// A four-entry command queue separates the front end from the back end, so the
// input stalls only when the queue fills while a waiting result is held off.
// An even kernel dimension makes every pixel or drain beat return one result
// with status set and no pixel.
module image_convolution_2d_top import icv_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [HEIGHT_BITS-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic [CIDX_BITS-1:0]          coef_index,
  input  logic signed [COEF_BITS-1:0]   coef_value,
  input  logic signed [PIXEL_BITS-1:0]  pixel_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [PIXEL_BITS-1:0]  out_pixel,
  output logic [COL_BITS-1:0]           out_col,
  output logic [EROW_BITS-1:0]          out_row,
  output logic                          frame_end,
  output logic                          status
);

  logic                 item_acc;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  cmd_t                 front_cmd;
  cmd_t                 back_cmd;
  logic [KDIM_BITS-1:0] win_top;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  // Input beats are taken while the queue has room.
  assign in_stall = q_full;
  assign item_acc = in_valid && !q_full;

  icv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_acc   (item_acc),
    .opcode     (opcode),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .pixel_value(pixel_value),
    .push       (q_push),
    .cmd        (front_cmd),
    .win_top    (win_top)
  );

  icv_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(front_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .pop_cmd (back_cmd),
    .empty   (q_empty)
  );

  icv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_cmd    (back_cmd),
    .pop      (q_pop),
    .win_top  (win_top),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_pixel(out_pixel),
    .out_col  (out_col),
    .out_row  (out_row),
    .frame_end(frame_end),
    .status   (status)
  );

  // The back end never pops an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("back end popped an empty command queue");

  // The front end never pushes into a full queue.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("front end pushed into a full command queue");

  // An error result carries no pixel, position or frame end.
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (out_pixel == '0 && out_col == '0 &&
                               out_row == '0 && !frame_end))
    else $error("error result carries pixel data");

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !out_valid)
    else $error("result offered right after reset");

endmodule

// File: sim/icv_checker.sv
// Result checker for the 2-D convolution block: watches the register port and
// both beat channels, predicts each filtered pixel and compares it. Uses icv_pkg.
module icv_checker import icv_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [HEIGHT_BITS-1:0]       cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   opcode,
  input  logic [CIDX_BITS-1:0]         coef_index,
  input  logic signed [COEF_BITS-1:0]  coef_value,
  input  logic signed [PIXEL_BITS-1:0] pixel_value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [PIXEL_BITS-1:0] out_pixel,
  input  logic [COL_BITS-1:0]          out_col,
  input  logic [EROW_BITS-1:0]         out_row,
  input  logic                         frame_end,
  input  logic                         status,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] pix;
    logic [COL_BITS-1:0]          col;
    logic [EROW_BITS-1:0]         row;
    logic                         fend;
    logic                         st;
  } filt_pixel_t;

  logic signed [PIXEL_BITS-1:0] line_ring [RING_ROWS*MAX_WIDTH];
  logic signed [COEF_BITS-1:0]  kernel_coef [MAX_KERNEL*MAX_KERNEL];
  int unsigned in_c, in_r, em_c, em_r;
  int unsigned reg_w, reg_h, reg_kc, reg_kr;
  filt_pixel_t filtered_q[$];

  assign pending = filtered_q.size();

  // Works out what one pixel or drain beat does to the window and what it emits.
  task automatic filter_beat(input logic [1:0] op, input logic signed [PIXEL_BITS-1:0] pv);
    int unsigned w, h, hr, hc, pos, lag;
    int y, x;
    longint acc, q;
    filt_pixel_t r;
    w = (reg_w == 0) ? 1 : ((reg_w > MAX_WIDTH) ? MAX_WIDTH : reg_w);
    h = (reg_h == 0) ? 1 : ((reg_h > MAX_HEIGHT) ? MAX_HEIGHT : reg_h);
    hr = reg_kr / 2;
    hc = reg_kc / 2;
    r = '0;
    if (reg_kc[0] == 1'b0 || reg_kr[0] == 1'b0) begin
      r.st = 1'b1;
      filtered_q = {filtered_q, r};
      return;
    end
    if (in_r < h && in_c < w)
      line_ring[(in_r % RING_ROWS) * MAX_WIDTH + in_c] = (op == OP_PIXEL) ? pv : '0;
    pos = in_r * w + in_c;
    lag = hr * w + ((hc < w - 1) ? hc : w - 1);
    if (pos >= lag) begin
      acc = 0;
      for (int ky = 0; ky < reg_kr; ky++) begin
        y = int'(em_r) + ky - int'(hr);
        if (y < 0 || y >= int'(h)) continue;
        for (int kx = 0; kx < reg_kc; kx++) begin
          x = int'(em_c) + kx - int'(hc);
          if (x < 0 || x >= int'(w)) continue;
          acc += longint'(kernel_coef[ky*MAX_KERNEL+kx]) *
                 longint'(line_ring[(y % RING_ROWS) * MAX_WIDTH + x]);
        end
      end
      q = acc / (longint'(1) << COEF_FRAC);
      if (q > PIX_MAX) q = PIX_MAX;
      if (q < PIX_MIN) q = PIX_MIN;
      r.pix = q[PIXEL_BITS-1:0];
      r.col = em_c[COL_BITS-1:0];
      r.row = em_r[EROW_BITS-1:0];
      em_c++;
      if (em_c >= w) begin
        em_c = 0;
        em_r++;
        r.fend = (em_r >= h);
      end
      filtered_q = {filtered_q, r};
      if (r.fend) begin
        in_c = 0; in_r = 0; em_c = 0; em_r = 0;
        return;
      end
    end
    in_c++;
    if (in_c >= w) begin
      in_c = 0;
      in_r++;
    end
  endtask

  // Track register writes and input beats, and check every output beat.
  always @(posedge clk) begin
    filt_pixel_t exp_r;
    if (rst) begin
      foreach (line_ring[i]) line_ring[i] = '0;
      foreach (kernel_coef[i]) kernel_coef[i] = '0;
      in_c = 0; in_r = 0; em_c = 0; em_r = 0;
      reg_w = 640; reg_h = 480; reg_kc = 3; reg_kr = 3;
      filtered_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected output beat: pixel %0d col %0d row %0d", out_pixel, out_col,
                 out_row);
          fail_count++;
        end else begin
          exp_r = filtered_q.pop_front();
          if (out_pixel !== exp_r.pix) begin
            $error("out_pixel: expected %0d, got %0d", exp_r.pix, out_pixel); fail_count++;
          end
          if (out_col !== exp_r.col) begin
            $error("out_col: expected %0d, got %0d", exp_r.col, out_col); fail_count++;
          end
          if (out_row !== exp_r.row) begin
            $error("out_row: expected %0d, got %0d", exp_r.row, out_row); fail_count++;
          end
          if (frame_end !== exp_r.fend) begin
            $error("frame_end: expected %0d, got %0d", exp_r.fend, frame_end); fail_count++;
          end
          if (status !== exp_r.st) begin
            $error("status: expected %0d, got %0d", exp_r.st, status); fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH:  reg_w = 32'(cfg_data[WIDTH_BITS-1:0]);
          CFG_HEIGHT: reg_h = 32'(cfg_data);
          CFG_KCOLS:  reg_kc = 32'(cfg_data[KDIM_BITS-1:0]);
          default:    reg_kr = 32'(cfg_data[KDIM_BITS-1:0]);
        endcase
        in_c = 0; in_r = 0; em_c = 0; em_r = 0;
      end
      if (in_valid && !in_stall) begin
        if (opcode == OP_COEF) begin
          if (coef_index < MAX_KERNEL*MAX_KERNEL) kernel_coef[coef_index] = coef_value;
        end else if (opcode != OP_NONE) begin
          filter_beat(opcode, pixel_value);
        end
      end
    end
  end

endmodule

// File: sim/tb_image_convolution_2d_top.sv
// Testbench top for the 2-D convolution block: drives register writes and beats
// with random gaps and stalls. Uses icv_pkg, image_convolution_2d_top, icv_checker.
module tb_image_convolution_2d_top;
  import icv_pkg::*;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [HEIGHT_BITS-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [1:0] opcode;
  logic [CIDX_BITS-1:0] coef_index;
  logic signed [COEF_BITS-1:0] coef_value;
  logic signed [PIXEL_BITS-1:0] pixel_value;
  logic out_valid, out_stall;
  logic signed [PIXEL_BITS-1:0] out_pixel;
  logic [COL_BITS-1:0] out_col;
  logic [EROW_BITS-1:0] out_row;
  logic frame_end, status;
  int fail_count, pending;
  int tx_gap_pct, rx_stall_pct, beats_sent;
  logic hold_req;

  image_convolution_2d_top u_dut (.*);

  icv_checker u_chk (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("tb_image_convolution_2d_top failed");
    $finish;
  end

  // Output stall: random, with one long hold-off on request.
  initial begin
    logic held;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
      end
      out_stall = ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Send one beat, with random idle cycles in front of it.
  task automatic send_beat(input logic [1:0] op, input logic [CIDX_BITS-1:0] ci,
                           input logic signed [COEF_BITS-1:0] cv,
                           input logic signed [PIXEL_BITS-1:0] pv);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = op; coef_index = ci; coef_value = cv; pixel_value = pv;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    beats_sent++;
    // Idling pattern moves on as the run progresses.
    if (beats_sent < 470) begin
      tx_gap_pct = 25; rx_stall_pct = 59;
    end else if (beats_sent < 940) begin
      tx_gap_pct = 59; rx_stall_pct = 25;
    end else begin
      tx_gap_pct = 0; rx_stall_pct = 0;
    end
  endtask

  // Wait for the block to go idle, then set all four registers.
  task automatic set_geometry(input int w, input int h, input int kc, input int kr);
    int vals [4];
    vals = '{w, h, kc, kr};
    wait (pending == 0);
    repeat (20) @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_valid = 1'b1;
      cfg_index = i[1:0];
      cfg_data = vals[i][HEIGHT_BITS-1:0];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
      cfg_valid = 1'b0;
    end
  endtask

  function automatic logic signed [PIXEL_BITS-1:0] rand_pixel();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return PIXEL_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_BITS-1:0] rand_coef();
    case ($urandom_range(7))
      0: return 18'sh1ffff;
      1: return 18'sh20000;
      2: return COEF_BITS'($urandom);
      default: return COEF_BITS'($urandom_range(8191) - 4096);
    endcase
  endfunction

  // Load coefficients, then stream one frame, or its first max_beats beats, with
  // noise mixed in; with an even kernel, send twelve pixel or drain beats instead.
  task automatic stream_frame(input int w_reg, input int h_reg, input int kc, input int kr,
                              input int max_beats);
    int w, h, lag, npix, nbeats;
    logic [1:0] op;
    w = (w_reg == 0) ? 1 : ((w_reg > MAX_WIDTH) ? MAX_WIDTH : w_reg);
    h = (h_reg == 0) ? 1 : ((h_reg > MAX_HEIGHT) ? MAX_HEIGHT : h_reg);
    for (int ky = 0; ky < MAX_KERNEL; ky++)
      for (int kx = 0; kx < MAX_KERNEL; kx++)
        if (ky < kr && kx < kc && $urandom_range(3) != 0)
          send_beat(OP_COEF, CIDX_BITS'(ky*MAX_KERNEL + kx), rand_coef(), rand_pixel());
    if (kc % 2 == 0 || kr % 2 == 0) begin
      for (int i = 0; i < 12; i++)
        send_beat($urandom_range(3) == 0 ? OP_DRAIN : OP_PIXEL, '0, '0, rand_pixel());
      return;
    end
    npix = w * h;
    lag = (kr / 2) * w + ((kc / 2 < w - 1) ? kc / 2 : w - 1);
    nbeats = (npix + lag > max_beats) ? max_beats : npix + lag;
    for (int i = 0; i < nbeats; i++) begin
      if ($urandom_range(19) == 0)
        send_beat($urandom_range(1) ? OP_NONE : OP_COEF, CIDX_BITS'($urandom), rand_coef(),
                  rand_pixel());
      // Early drains and extra pixels are occasional swaps of the opcode.
      if (i < npix) op = ($urandom_range(19) == 0) ? OP_DRAIN : OP_PIXEL;
      else op = ($urandom_range(19) == 0) ? OP_PIXEL : OP_DRAIN;
      send_beat(op, CIDX_BITS'($urandom), COEF_BITS'($urandom), rand_pixel());
      if (i == npix / 2 && $urandom_range(3) == 0) wait (pending == 0);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int rand_start, kc, kr, gw, gh;
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = CFG_WIDTH; cfg_data = '0;
    in_valid = 1'b0; opcode = OP_NONE; coef_index = '0; coef_value = '0; pixel_value = '0;
    tx_gap_pct = 25; rx_stall_pct = 59; beats_sent = 0; hold_req = 1'b0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Directed: 3x3 frame with coefficient and pixel extremes and the odd cases.
    set_geometry(3, 3, 3, 3);
    send_beat(OP_COEF, 6'd0, 18'sh20000, '0);
    send_beat(OP_COEF, 6'd8, 18'sh1ffff, '0);
    send_beat(OP_COEF, 6'd48, 18'sh1ffff, '0);
    send_beat(OP_COEF, 6'd49, 18'sh1ffff, '0);
    send_beat(OP_COEF, 6'd63, 18'sh20000, '0);
    send_beat(OP_COEF, 6'd2, 18'sh00800, '0);
    send_beat(OP_NONE, 6'h3f, 18'sh3ffff, 16'shffff);
    send_beat(OP_PIXEL, '0, '0, 16'sh7fff);
    send_beat(OP_PIXEL, '0, '0, 16'sh8000);
    send_beat(OP_PIXEL, '0, '0, 16'sh7fff);
    send_beat(OP_DRAIN, '0, '0, 16'sh1234);
    send_beat(OP_PIXEL, '0, '0, 16'sh8000);
    send_beat(OP_PIXEL, '0, '0, '0);
    send_beat(OP_PIXEL, '0, '0, 16'sh7fff);
    send_beat(OP_PIXEL, '0, '0, 16'sh0001);
    send_beat(OP_PIXEL, '0, '0, 16'sh8000);
    send_beat(OP_DRAIN, '0, '0, '0);
    send_beat(OP_PIXEL, '0, '0, 16'sh5555);
    send_beat(OP_DRAIN, '0, '0, '0);
    send_beat(OP_DRAIN, '0, '0, '0);

    // Fixed geometries covering the register extremes; the oversized ones are
    // only streamed in part and then restarted by the next register write.
    set_geometry(5, 4, 3, 3);       stream_frame(5, 4, 3, 3, 1000);
    set_geometry(1, 1, 1, 1);       stream_frame(1, 1, 1, 1, 1000);
    set_geometry(7, 7, 7, 7);       stream_frame(7, 7, 7, 7, 1000);
    set_geometry(0, 0, 5, 3);       stream_frame(0, 0, 5, 3, 1000);
    set_geometry(3, 6, 7, 1);       stream_frame(3, 6, 7, 1, 1000);
    set_geometry(4, 3, 2, 3);       stream_frame(4, 3, 2, 3, 1000);
    set_geometry(4, 3, 3, 0);       stream_frame(4, 3, 3, 0, 1000);
    set_geometry(4095, 1, 7, 1);    stream_frame(4095, 1, 7, 1, 100);
    set_geometry(1, 8191, 1, 3);    stream_frame(1, 8191, 1, 3, 100);

    // Random geometries; one long output hold-off near the start.
    rand_start = beats_sent;
    hold_req = 1'b1;
    while (beats_sent - rand_start < 950) begin
      kc = ($urandom_range(7) == 0) ? 2 * $urandom_range(3) : 2 * $urandom_range(3) + 1;
      kr = ($urandom_range(7) == 0) ? 2 * $urandom_range(3) : 2 * $urandom_range(3) + 1;
      gw = $urandom_range(1, 12);
      gh = $urandom_range(1, 8);
      set_geometry(gw, gh, kc, kr);
      stream_frame(gw, gh, kc, kr, 1000);
    end

    wait (pending == 0);
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("tb_image_convolution_2d_top passed");
    else
      $display("tb_image_convolution_2d_top failed");
    $finish;
  end

endmodule

// File: files.f
hdl/icv_pkg.sv
hdl/icv_ram.sv
hdl/icv_front.sv
hdl/icv_queue.sv
hdl/icv_back.sv
hdl/image_convolution_2d_top.sv
sim/icv_checker.sv
sim/tb_image_convolution_2d_top.sv
